// File: rtl/core/multilevel_ready_queue_defines.svh
// Assertion macros used by the checker module of the multilevel ready queue.
// Needs a clock named aclk and an active-low reset named aresetn in the scope of use.
`ifndef MULTILEVEL_READY_QUEUE_DEFINES_SVH
`define MULTILEVEL_READY_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mrq_pkg.sv
// Package of the multilevel ready queue: sizes, null and state codes, opcodes.
// No dependencies; used by multilevel_ready_queue.
`default_nettype none

package mrq_pkg;

    // Table and queue sizes.
    localparam int NUM_ENTRIES = 32;
    localparam int NUM_LEVELS  = 5;
    localparam int NUM_QUEUES  = NUM_LEVELS + 1;

    // Field widths of the request and result payload.
    localparam int ENTRY_W = 5;
    localparam int LEVEL_W = 3;
    localparam int OP_W    = 3;

    // Internal widths: an entry address, a link (entry or null), a queue and a state code.
    localparam int ADDR_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int LINK_W  = $clog2(NUM_ENTRIES + 1);
    localparam int QUEUE_W = $clog2(NUM_QUEUES);
    localparam int STATE_W = $clog2(NUM_LEVELS + 3);

    // Null link and special queue and state codes.
    localparam logic [LINK_W-1:0]  NIL_LINK   = LINK_W'(NUM_ENTRIES);
    localparam logic [QUEUE_W-1:0] FREE_Q     = QUEUE_W'(NUM_LEVELS);
    localparam logic [STATE_W-1:0] ST_FREE    = STATE_W'(NUM_LEVELS);
    localparam logic [STATE_W-1:0] ST_RUNNING = STATE_W'(NUM_LEVELS + 1);
    localparam logic [STATE_W-1:0] ST_BLOCKED = STATE_W'(NUM_LEVELS + 2);

    // Request opcodes.
    typedef enum logic [OP_W-1:0] {
        OP_READY     = 3'd0,
        OP_STOP      = 3'd1,
        OP_NEXT      = 3'd2,
        OP_TAKE_FREE = 3'd3,
        OP_BLOCK     = 3'd4,
        OP_REMOVE    = 3'd5
    } opcode_t;

endpackage

`default_nettype wire

// File: rtl/core/multilevel_ready_queue.sv
// Multilevel ready queue: linked FIFOs of task entries kept in two link/state memories.
// Depends on mrq_pkg.
//
// Channel  Dir  Payload (lowest bit first)                          Handshake
// s_       in   tdata: entry_index[4:0], priority_level[7:5];      s_tvalid / s_tready
//               tuser: opcode[2:0]
// m_       out  tdata: result_entry[4:0], zero[7:5]; tuser: found  m_tvalid / m_tready
//
// One request at a time; the next request is accepted once a result is loaded.
// Next and take_free pop the head of a queue. Block and remove walk the queue that holds
// the entry to unlink it; ready and stop walk it too and then append the entry to the
// tail of a queue. Each step of the walk is one read of the link memory.
// Reset is synchronous; written-bits stand in for the reset image of the memories, so no
// clearing pass is needed and a request is accepted as soon as reset is released.
// A stalled result sits in the output register; the next request is still accepted.
`default_nettype none

module multilevel_ready_queue (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [4:0] entry_index, [7:5] priority_level
    input  wire logic [2:0] s_tuser,   // [2:0] opcode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [4:0] result_entry, [7:5] zero
    output logic [0:0]      m_tuser    // [0] found
);

    localparam int NE  = mrq_pkg::NUM_ENTRIES;
    localparam int NQ  = mrq_pkg::NUM_QUEUES;
    localparam int AW  = mrq_pkg::ADDR_W;
    localparam int LW  = mrq_pkg::LINK_W;
    localparam int QW  = mrq_pkg::QUEUE_W;
    localparam int SW  = mrq_pkg::STATE_W;
    localparam int EW  = mrq_pkg::ENTRY_W;
    localparam int LVW = mrq_pkg::LEVEL_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_STATE_RD,
        S_WALK,
        S_WALK_RD,
        S_DETACHED,
        S_APPEND,
        S_APPEND_LINK,
        S_POP_RD,
        S_FINISH
    } fsm_t;

    // Request fields.
    logic [EW-1:0]  s_entry;
    logic [LVW-1:0] s_level;
    assign s_entry = s_tdata[EW-1:0];
    assign s_level = s_tdata[EW+LVW-1:EW];

    // Control and working registers.
    fsm_t             fsm_reg, fsm_next;
    mrq_pkg::opcode_t op_reg, op_next;
    logic [AW-1:0]    entry_reg, entry_next;
    logic             entry_ok_reg, entry_ok_next;
    logic [QW-1:0]    lvl_reg, lvl_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [LW-1:0]    cur_reg, cur_next;
    logic [LW-1:0]    prev_reg, prev_next;
    logic             found_reg, found_next;
    logic [AW-1:0]    res_reg, res_next;
    logic [LW-1:0]    head_reg [NQ];
    logic [LW-1:0]    head_next [NQ];
    logic [LW-1:0]    tail_reg [NQ];
    logic [LW-1:0]    tail_next [NQ];

    // Output register.
    logic          m_valid_reg, m_valid_next;
    logic [EW-1:0] m_entry_reg, m_entry_next;
    logic          m_found_reg, m_found_next;

    // Link memory and entry state memory, each with one write and one read port.
    logic [LW-1:0] link_mem [NE];
    logic [SW-1:0] state_mem [NE];
    logic [NE-1:0] link_written_reg;
    logic [NE-1:0] state_written_reg;

    logic          link_we, link_re;
    logic [AW-1:0] link_wa, link_ra;
    logic [LW-1:0] link_wd;
    logic [LW-1:0] link_raw_reg;
    logic          link_ok_reg;
    logic [AW-1:0] link_ra_reg;
    logic [LW-1:0] link_rd;

    logic          state_we, state_re;
    logic [AW-1:0] state_wa, state_ra;
    logic [SW-1:0] state_wd;
    logic [SW-1:0] state_raw_reg;
    logic          state_ok_reg;
    logic [SW-1:0] state_rd;

    // Lowest-numbered non-empty served level.
    logic          lvl_any;
    logic [QW-1:0] lvl_sel;

    always_comb begin
        lvl_any = 1'b0;
        lvl_sel = '0;
        for (int q = mrq_pkg::NUM_LEVELS - 1; q >= 0; q--) begin
            if (head_reg[q] != mrq_pkg::NIL_LINK) begin
                lvl_any = 1'b1;
                lvl_sel = QW'(q);
            end
        end
    end

    // An entry never written still holds its reset image: linked to the next index, and free.
    assign link_rd  = link_ok_reg ? link_raw_reg : (LW'(link_ra_reg) + LW'(1));
    assign state_rd = state_ok_reg ? state_raw_reg : mrq_pkg::ST_FREE;

    // Sequencer: decode, state read, queue walk, unlink, append or pop, result.
    always_comb begin
        fsm_next      = fsm_reg;
        op_next       = op_reg;
        entry_next    = entry_reg;
        entry_ok_next = entry_ok_reg;
        lvl_next      = lvl_reg;
        q_next        = q_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        found_next    = found_reg;
        res_next      = res_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        m_valid_next  = m_valid_reg;
        m_entry_next  = m_entry_reg;
        m_found_next  = m_found_reg;
        link_we       = 1'b0;
        link_wa       = '0;
        link_wd       = '0;
        link_re       = 1'b0;
        link_ra       = '0;
        state_we      = 1'b0;
        state_wa      = '0;
        state_wd      = '0;
        state_re      = 1'b0;
        state_ra      = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (fsm_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next       = mrq_pkg::opcode_t'(s_tuser);
                    entry_next    = AW'(s_entry);
                    entry_ok_next = (int'(s_entry) < NE);
                    lvl_next      = (int'(s_level) >= mrq_pkg::NUM_LEVELS)
                                    ? QW'(mrq_pkg::NUM_LEVELS - 1) : QW'(s_level);
                    found_next    = 1'b0;
                    res_next      = '0;
                    fsm_next      = S_DECODE;
                end
            end
            S_DECODE: begin
                case (op_reg) inside
                    mrq_pkg::OP_READY, mrq_pkg::OP_STOP,
                    mrq_pkg::OP_BLOCK, mrq_pkg::OP_REMOVE: begin
                        if (entry_ok_reg) begin
                            state_re = 1'b1;
                            state_ra = entry_reg;
                            fsm_next = S_STATE_RD;
                        end else begin
                            fsm_next = S_FINISH;
                        end
                    end
                    mrq_pkg::OP_NEXT: begin
                        if (lvl_any) begin
                            q_next   = lvl_sel;
                            cur_next = head_reg[lvl_sel];
                            link_re  = 1'b1;
                            link_ra  = head_reg[lvl_sel][AW-1:0];
                            fsm_next = S_POP_RD;
                        end else begin
                            fsm_next = S_FINISH;
                        end
                    end
                    mrq_pkg::OP_TAKE_FREE: begin
                        if (head_reg[mrq_pkg::FREE_Q] != mrq_pkg::NIL_LINK) begin
                            q_next   = mrq_pkg::FREE_Q;
                            cur_next = head_reg[mrq_pkg::FREE_Q];
                            link_re  = 1'b1;
                            link_ra  = head_reg[mrq_pkg::FREE_Q][AW-1:0];
                            fsm_next = S_POP_RD;
                        end else begin
                            fsm_next = S_FINISH;
                        end
                    end
                    default: begin
                        fsm_next = S_FINISH;
                    end
                endcase
            end
            S_POP_RD: begin
                // The head's link becomes the new head; an emptied queue loses its tail.
                head_next[q_reg] = link_rd;
                if (link_rd == mrq_pkg::NIL_LINK) begin
                    tail_next[q_reg] = mrq_pkg::NIL_LINK;
                end
                state_we   = 1'b1;
                state_wa   = cur_reg[AW-1:0];
                state_wd   = mrq_pkg::ST_RUNNING;
                found_next = 1'b1;
                res_next   = cur_reg[AW-1:0];
                fsm_next   = S_FINISH;
            end
            S_STATE_RD: begin
                // Running and blocked entries are on no queue.
                if (int'(state_rd) >= NQ) begin
                    fsm_next = S_DETACHED;
                end else begin
                    q_next    = state_rd[QW-1:0];
                    cur_next  = head_reg[state_rd[QW-1:0]];
                    prev_next = mrq_pkg::NIL_LINK;
                    fsm_next  = S_WALK;
                end
            end
            S_WALK: begin
                if (cur_reg == mrq_pkg::NIL_LINK) begin
                    fsm_next = S_DETACHED;
                end else begin
                    link_re  = 1'b1;
                    link_ra  = cur_reg[AW-1:0];
                    fsm_next = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (cur_reg == LW'(entry_reg)) begin
                    // Unlink the target: its successor goes to the head or to its predecessor.
                    found_next = 1'b1;
                    if (prev_reg == mrq_pkg::NIL_LINK) begin
                        head_next[q_reg] = link_rd;
                    end else begin
                        link_we = 1'b1;
                        link_wa = prev_reg[AW-1:0];
                        link_wd = link_rd;
                    end
                    if (tail_reg[q_reg] == LW'(entry_reg)) begin
                        tail_next[q_reg] = prev_reg;
                    end
                    fsm_next = S_DETACHED;
                end else begin
                    prev_next = cur_reg;
                    cur_next  = link_rd;
                    fsm_next  = S_WALK;
                end
            end
            S_DETACHED: begin
                res_next = entry_reg;
                case (op_reg)
                    mrq_pkg::OP_READY: begin
                        found_next = 1'b0;
                        q_next     = lvl_reg;
                        fsm_next   = S_APPEND;
                    end
                    mrq_pkg::OP_STOP: begin
                        found_next = 1'b0;
                        q_next     = mrq_pkg::FREE_Q;
                        fsm_next   = S_APPEND;
                    end
                    mrq_pkg::OP_BLOCK: begin
                        state_we = 1'b1;
                        state_wa = entry_reg;
                        state_wd = mrq_pkg::ST_BLOCKED;
                        fsm_next = S_FINISH;
                    end
                    default: begin
                        fsm_next = S_FINISH;
                    end
                endcase
            end
            S_APPEND: begin
                // The entry becomes the new tail and takes the queue's state code.
                link_we  = 1'b1;
                link_wa  = entry_reg;
                link_wd  = mrq_pkg::NIL_LINK;
                state_we = 1'b1;
                state_wa = entry_reg;
                state_wd = (op_reg == mrq_pkg::OP_READY) ? SW'(lvl_reg) : mrq_pkg::ST_FREE;
                if (head_reg[q_reg] == mrq_pkg::NIL_LINK ||
                    tail_reg[q_reg] == mrq_pkg::NIL_LINK) begin
                    head_next[q_reg] = LW'(entry_reg);
                    tail_next[q_reg] = LW'(entry_reg);
                    fsm_next         = S_FINISH;
                end else begin
                    fsm_next = S_APPEND_LINK;
                end
            end
            S_APPEND_LINK: begin
                link_we          = 1'b1;
                link_wa          = tail_reg[q_reg][AW-1:0];
                link_wd          = LW'(entry_reg);
                tail_next[q_reg] = LW'(entry_reg);
                fsm_next         = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_entry_next = found_reg ? EW'(res_reg) : '0;
                    m_found_next = found_reg;
                    fsm_next     = S_IDLE;
                end
            end
            default: begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    // Sequencer, queue pointers and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int q = 0; q < NQ; q++) begin
                head_reg[q] <= mrq_pkg::NIL_LINK;
                tail_reg[q] <= mrq_pkg::NIL_LINK;
            end
            head_reg[mrq_pkg::FREE_Q] <= '0;
            tail_reg[mrq_pkg::FREE_Q] <= LW'(NE - 1);
        end else begin
            fsm_reg     <= fsm_next;
            m_valid_reg <= m_valid_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
        end
        op_reg       <= op_next;
        entry_reg    <= entry_next;
        entry_ok_reg <= entry_ok_next;
        lvl_reg      <= lvl_next;
        q_reg        <= q_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        found_reg    <= found_next;
        res_reg      <= res_next;
        m_entry_reg  <= m_entry_next;
        m_found_reg  <= m_found_next;
    end

    // Written-bits: an entry reads its reset image until its first write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_written_reg  <= '0;
            state_written_reg <= '0;
        end else begin
            if (link_we) begin
                link_written_reg[link_wa] <= 1'b1;
            end
            if (state_we) begin
                state_written_reg[state_wa] <= 1'b1;
            end
        end
        if (link_re) begin
            link_ok_reg <= link_written_reg[link_ra];
            link_ra_reg <= link_ra;
        end
        if (state_re) begin
            state_ok_reg <= state_written_reg[state_ra];
        end
    end

    // Memory arrays with registered read data.
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (link_re) begin
            link_raw_reg <= link_mem[link_ra];
        end
        if (state_we) begin
            state_mem[state_wa] <= state_wd;
        end
        if (state_re) begin
            state_raw_reg <= state_mem[state_ra];
        end
    end

    assign s_tready   = (fsm_reg == S_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {(8 - EW)'(0), m_entry_reg};
    assign m_tuser[0] = m_found_reg;

endmodule

`default_nettype wire

// File: rtl/core/mrq_checker.sv
// Port checker of the multilevel ready queue, bound to the top level.
// Depends on multilevel_ready_queue_defines.svh and multilevel_ready_queue.
`default_nettype none
`include "multilevel_ready_queue_defines.svh"

module mrq_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [0:0] m_tuser
);

    // Stalled result, result without a found entry, and the whole result payload.
    logic       m_stall;
    logic       m_miss;
    logic [8:0] m_payload;
    assign m_stall   = m_tvalid && !m_tready;
    assign m_miss    = m_tvalid && !m_tuser[0];
    assign m_payload = {m_tuser, m_tdata};

    // A stalled result holds its payload.
    `MRQ_ASSERT_NEXT(a_hold, m_stall, m_tvalid && $stable(m_payload), "stalled result changed")

    // A result without a found entry carries entry zero.
    `MRQ_ASSERT_SAME(a_miss_zero, m_miss, m_tdata == 8'd0, "nonzero entry without found")

    // Requests are worked one at a time: the input closes right after an accepted request.
    `MRQ_ASSERT_NEXT(a_single, s_tvalid && s_tready, !s_tready, "request accepted while busy")

endmodule

bind multilevel_ready_queue mrq_checker u_mrq_checker (.*);

`default_nettype wire
